// ===== rtl/lfsb_pkg.sv =====
// lfsb_pkg: types and constants for the loop frame serial bridge
// no dependencies; used by the top level and its checker

package lfsb_pkg;

  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_AW    = 2;
  localparam int unsigned FIFO_CW    = 3;

  typedef enum logic [1:0] {
    CMD_SEND  = 2'd0,
    CMD_RXB   = 2'd1,
    CMD_TICK  = 2'd2,
    CMD_DEVRP = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    KIND_TXB   = 2'd0,
    KIND_REPLY = 2'd1,
    KIND_HOST  = 2'd2,
    KIND_ERR   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    REG_SHORT   = 2'd0,
    REG_COMMAND = 2'd1,
    REG_LONG    = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  tx_byte;
    logic [10:0] frame_out;
    logic        last;
  } res_t;

  localparam logic [15:0] SHORT_RST   = 16'd3000;
  localparam logic [15:0] COMMAND_RST = 16'd10000;
  localparam logic [15:0] LONG_RST    = 16'd30000;

  localparam logic [10:0] SPECIAL_MASK = 11'h794;
  localparam logic [10:0] SPECIAL_VAL  = 11'h494;
  localparam logic [10:0] FR_494       = 11'h494;
  localparam logic [10:0] FR_496       = 11'h496;
  localparam logic [10:0] FR_497       = 11'h497;
  localparam logic [10:0] IDY_BASE     = 11'h600;
  localparam logic [2:0]  CLS_IDY      = 3'd6;
  localparam logic [2:0]  CLS_CMD      = 3'd4;
  localparam logic [7:0]  ACK_BYTE     = 8'd13;

endpackage

// ===== rtl/loop_frame_serial_bridge.sv =====
// loop_frame_serial_bridge: loop frame to serial byte bridge, top level
// depends on lfsb_pkg
//
//   channel | signals                                      | direction
//   in      | in_valid/in_ready, command, frame_in, rx_byte | to block
//   out     | out_valid/out_ready, kind, tx_byte, frame_out, last | from block
//   cfg     | cfg_we, cfg_index, cfg_wdata                  | to block
//
// an accepted item is held in the input register, then one pass of
// logic updates the loop state and pushes zero to two results into a
// four-entry result queue; the queue drains one result per cycle while
// out_ready is high, so the sustained rate is one item per cycle for
// single-result items (items with two results are limited by the output port)
// an item leaves the input register only when the queue has two free slots
// reset (synchronous, rst_n low) empties both stages and loads the limits

module loop_frame_serial_bridge (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_command,
  input  logic [10:0] in_frame_in,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_kind,
  output logic [7:0]  out_tx_byte,
  output logic [10:0] out_frame_out,
  output logic        out_last,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);
  import lfsb_pkg::*;

  // configuration
  logic [15:0] short_limit_r, command_limit_r, long_limit_r;

  // input register
  logic        iv_r;
  logic [1:0]  icmd_r;
  logic [10:0] ifr_r;
  logic [7:0]  irb_r;

  // loop state
  logic [5:0]  last_high_r, last_high_nxt;
  logic        broken_r, broken_nxt;
  logic        waiting_r, waiting_nxt;
  logic [10:0] pending_r, pending_nxt;
  logic [15:0] tick_count_r, tick_count_nxt;
  logic [15:0] tick_limit_r, tick_limit_nxt;

  // result queue
  res_t               fifo_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [FIFO_CW-1:0] count_r;

  logic       fire, pop;
  logic [1:0] n_res;
  res_t       res0, res1;

  assign fire     = iv_r && (count_r <= FIFO_CW'(FIFO_DEPTH - 2));
  assign in_ready = !iv_r || fire;
  assign pop      = out_valid && out_ready;

  assign out_valid     = (count_r != '0);
  assign out_kind      = fifo_r[rd_ptr_r].kind;
  assign out_tx_byte   = fifo_r[rd_ptr_r].tx_byte;
  assign out_frame_out = fifo_r[rd_ptr_r].frame_out;
  assign out_last      = fifo_r[rd_ptr_r].last;

  always_comb begin
    logic [7:0]  hb;
    logic [7:0]  lb;
    logic [5:0]  lh_eff;
    logic [2:0]  cls;
    logic [15:0] tc_base;
    logic [10:0] dec;
    res_t        step_res;
    logic        do_step;
    logic        special;

    last_high_nxt  = last_high_r;
    broken_nxt     = broken_r;
    waiting_nxt    = waiting_r;
    pending_nxt    = pending_r;
    tick_count_nxt = tick_count_r;
    tick_limit_nxt = tick_limit_r;
    res0           = '0;
    res1           = '0;
    n_res          = 2'd0;

    hb      = {3'b001, ifr_r[10:7], 1'b0};
    lb      = {1'b1, ifr_r[6:0]};
    cls     = ifr_r[10:8];
    special = ((ifr_r & SPECIAL_MASK) == SPECIAL_VAL);
    lh_eff  = last_high_r;
    tc_base = tick_count_r;
    do_step = 1'b0;
    if (irb_r[7]) begin
      dec = {last_high_r[4:1], irb_r[6:0]};
    end else begin
      dec = {last_high_r[4:0], irb_r[5:0]};
    end
    step_res      = '0;
    step_res.last = 1'b1;
    if (pending_r < IDY_BASE) begin
      step_res.kind = KIND_ERR;
    end else begin
      step_res.kind      = KIND_REPLY;
      step_res.frame_out = pending_r;
    end

    if (fire) begin
      case (cmd_t'(icmd_r))
        CMD_SEND, CMD_DEVRP: begin
          if (cmd_t'(icmd_r) == CMD_SEND && special) begin
            lh_eff = '0;
          end
          if (cmd_t'(icmd_r) == CMD_SEND && !special && cls < CLS_IDY && broken_r) begin
            res0.kind      = KIND_REPLY;
            res0.frame_out = ifr_r;
            res0.last      = 1'b1;
            n_res          = 2'd1;
          end else begin
            // high byte only goes out when it changes, or always for a special send frame
            if (hb[5:0] != lh_eff) begin
              res0.kind    = KIND_TXB;
              res0.tx_byte = hb;
              res1.kind    = KIND_TXB;
              res1.tx_byte = lb;
              res1.last    = 1'b1;
              n_res        = 2'd2;
            end else begin
              res0.kind    = KIND_TXB;
              res0.tx_byte = lb;
              res0.last    = 1'b1;
              n_res        = 2'd1;
            end
            last_high_nxt = hb[5:0];
            if (cmd_t'(icmd_r) == CMD_SEND) begin
              if (cls >= CLS_IDY) begin
                tick_limit_nxt = short_limit_r;
              end else if (ifr_r == FR_494 || ifr_r == FR_496 || ifr_r == FR_497) begin
                tick_limit_nxt = short_limit_r;
              end else if (cls == CLS_CMD) begin
                tick_limit_nxt = command_limit_r;
              end else begin
                tick_limit_nxt = long_limit_r;
              end
              tick_count_nxt = '0;
              broken_nxt     = 1'b0;
              waiting_nxt    = 1'b1;
              pending_nxt    = ifr_r;
            end
          end
        end
        CMD_RXB: begin
          if (irb_r[7:6] == 2'b00) begin
            if (irb_r[5]) begin
              last_high_nxt = irb_r[5:0];
              res0.kind     = KIND_TXB;
              res0.tx_byte  = ACK_BYTE;
              res0.last     = 1'b1;
              n_res         = 2'd1;
              tc_base       = '0;
            end
            do_step = waiting_r;
          end else begin
            res0.frame_out = dec;
            res0.last      = 1'b1;
            n_res          = 2'd1;
            if (waiting_r) begin
              res0.kind   = KIND_REPLY;
              waiting_nxt = 1'b0;
            end else begin
              res0.kind = KIND_HOST;
            end
          end
        end
        CMD_TICK: begin
          do_step = waiting_r;
        end
        default: begin
          n_res = 2'd0;
        end
      endcase

      if (do_step) begin
        if (tc_base >= tick_limit_r) begin
          waiting_nxt = 1'b0;
          broken_nxt  = 1'b1;
          if (n_res == 2'd1) begin
            // ack followed by the timeout result
            res0.last = 1'b0;
            res1      = step_res;
            n_res     = 2'd2;
          end else begin
            res0  = step_res;
            n_res = 2'd1;
          end
        end else begin
          tick_count_nxt = tc_base + 16'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      short_limit_r   <= SHORT_RST;
      command_limit_r <= COMMAND_RST;
      long_limit_r    <= LONG_RST;
      iv_r            <= 1'b0;
      last_high_r     <= '0;
      broken_r        <= 1'b0;
      waiting_r       <= 1'b0;
      tick_count_r    <= '0;
      tick_limit_r    <= '0;
      wr_ptr_r        <= '0;
      rd_ptr_r        <= '0;
      count_r         <= '0;
    end else begin
      if (cfg_we) begin
        case (reg_idx_t'(cfg_index))
          REG_SHORT:   short_limit_r   <= cfg_wdata;
          REG_COMMAND: command_limit_r <= cfg_wdata;
          REG_LONG:    long_limit_r    <= cfg_wdata;
          default:     short_limit_r   <= short_limit_r;
        endcase
      end
      if (in_ready) begin
        iv_r <= in_valid;
      end
      last_high_r  <= last_high_nxt;
      broken_r     <= broken_nxt;
      waiting_r    <= waiting_nxt;
      tick_count_r <= tick_count_nxt;
      tick_limit_r <= tick_limit_nxt;
      wr_ptr_r     <= wr_ptr_r + FIFO_AW'(n_res);
      rd_ptr_r     <= rd_ptr_r + FIFO_AW'(pop);
      count_r      <= count_r + FIFO_CW'(n_res) - FIFO_CW'(pop);
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      icmd_r <= in_command;
      ifr_r  <= in_frame_in;
      irb_r  <= in_rx_byte;
    end
    pending_r <= pending_nxt;
    if (n_res != 2'd0) begin
      fifo_r[wr_ptr_r] <= res0;
    end
    if (n_res == 2'd2) begin
      fifo_r[wr_ptr_r + FIFO_AW'(1)] <= res1;
    end
  end

endmodule

// ===== rtl/lfsb_checker.sv =====
// lfsb_checker: port-level checks for the loop frame serial bridge
// depends on lfsb_pkg; bound to loop_frame_serial_bridge below

module lfsb_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_kind,
  input logic [7:0]  out_tx_byte,
  input logic [10:0] out_frame_out,
  input logic        out_last
);
  import lfsb_pkg::*;

  // a stalled result transfer keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_kind) && $stable(out_tx_byte)
      && $stable(out_frame_out) && $stable(out_last))
    else $error("result changed while stalled");

  // frames and errors are always the final result of their item
  a_frame_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind != KIND_TXB |-> out_last && out_tx_byte == 8'd0)
    else $error("frame or error result malformed");

  a_byte_noframe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == KIND_TXB || out_kind == KIND_ERR) |-> out_frame_out == 11'd0)
    else $error("frame field set on byte or error result");

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind loop_frame_serial_bridge lfsb_checker u_lfsb_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_kind      (out_kind),
  .out_tx_byte   (out_tx_byte),
  .out_frame_out (out_frame_out),
  .out_last      (out_last)
);
